// File: hdl/euler_frame_point_transform_top_assert.svh
// Assertion macros for the Euler frame point transform checker.
// Depends on nothing; included by the checker file only.
`ifndef EULER_FRAME_POINT_TRANSFORM_TOP_ASSERT_SVH
`define EULER_FRAME_POINT_TRANSFORM_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle (consequent may hold a delay).
`define EFT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eft assertion failed");

// Antecedent implies consequent in the next cycle.
`define EFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eft assertion failed");

`endif

// File: hdl/eft_pkg.sv
// Shared types, constants and arithmetic helpers of the Euler frame point transform.
// Depends on nothing; used by every module of the block.
package eft_pkg;

   localparam int TRIG_BITS    = 16;
   localparam int COORD_BITS   = 32;
   localparam int TRIG_FRAC    = TRIG_BITS - 1;
   localparam int CORDIC_STEPS = 24;
   localparam int CNT_W        = $clog2(CORDIC_STEPS);
   localparam int XW           = 34;   // CORDIC x/y datapath, Q2.30 plus growth
   localparam int ZW           = 33;   // CORDIC angle residue
   localparam int PROD_W       = COORD_BITS + TRIG_BITS;
   localparam int WIDE         = (PROD_W + 2 > 34) ? PROD_W + 2 : 34;
   localparam int OUT_BITS     = 32;
   localparam int PIPE_LAT     = 10;

   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
   localparam logic signed [XW:0] TRIG_RND = (XW+1)'(64'sd1 <<< (29 - TRIG_FRAC));
   localparam logic signed [XW:0] TRIG_LIM = (XW+1)'((64'sd1 <<< TRIG_FRAC) - 1);
   localparam logic signed [WIDE-1:0] PROD_HALF = WIDE'(64'sd1 <<< (TRIG_FRAC - 1));

   typedef enum logic [1:0] {
      FUNC_BWD    = 2'd0,
      FUNC_FWD    = 2'd1,
      FUNC_CHILD  = 2'd2,
      FUNC_PARENT = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_ANGLE_X  = 3'd0,
      CSR_ANGLE_Y  = 3'd1,
      CSR_ANGLE_Z  = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4,
      CSR_OFFSET_Z = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      ROT_FIRST = 2'd0,
      ROT_MID   = 2'd1,
      ROT_LAST  = 2'd2
   } rot_pos_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic signed [TRIG_BITS-1:0] cx;
      logic signed [TRIG_BITS-1:0] sx;
      logic signed [TRIG_BITS-1:0] cy;
      logic signed [TRIG_BITS-1:0] sy;
      logic signed [TRIG_BITS-1:0] cz;
      logic signed [TRIG_BITS-1:0] sz;
   } trig_type;

   typedef struct packed {
      logic                         valid;
      func_type                     func;
      logic                         flag;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } stage_type;

   function automatic logic signed [ZW-1:0] atan_turn(logic [CNT_W-1:0] i);
      case (i)
         5'd0:    return ZW'(536870912);
         5'd1:    return ZW'(316933406);
         5'd2:    return ZW'(167458907);
         5'd3:    return ZW'(85004756);
         5'd4:    return ZW'(42667331);
         5'd5:    return ZW'(21354465);
         5'd6:    return ZW'(10679838);
         5'd7:    return ZW'(5340245);
         5'd8:    return ZW'(2670163);
         5'd9:    return ZW'(1335087);
         5'd10:   return ZW'(667544);
         5'd11:   return ZW'(333772);
         5'd12:   return ZW'(166886);
         5'd13:   return ZW'(83443);
         5'd14:   return ZW'(41722);
         5'd15:   return ZW'(20861);
         5'd16:   return ZW'(10430);
         5'd17:   return ZW'(5215);
         5'd18:   return ZW'(2608);
         5'd19:   return ZW'(1304);
         5'd20:   return ZW'(652);
         5'd21:   return ZW'(326);
         5'd22:   return ZW'(163);
         5'd23:   return ZW'(81);
         default: return '0;
      endcase
   endfunction

   // Round Q2.30 to Q1.TRIG_FRAC, clamp to the symmetric code range.
   function automatic logic signed [TRIG_BITS-1:0] to_trig(logic signed [XW:0] v);
      logic signed [XW:0] r;
      r = (v + TRIG_RND) >>> (30 - TRIG_FRAC);
      if (r > TRIG_LIM) r = TRIG_LIM;
      if (r < -TRIG_LIM) r = -TRIG_LIM;
      return r[TRIG_BITS-1:0];
   endfunction

   function automatic logic coord_ovf(logic signed [WIDE-1:0] v);
      logic [WIDE-COORD_BITS:0] hi;
      hi = v[WIDE-1:COORD_BITS-1];
      return !((&hi) || (~|hi));
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_coord(logic signed [WIDE-1:0] v);
      if (coord_ovf(v))
         return v[WIDE-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
      return v[COORD_BITS-1:0];
   endfunction

   function automatic logic out_ovf(logic signed [WIDE-1:0] v);
      logic [WIDE-OUT_BITS:0] hi;
      hi = v[WIDE-1:OUT_BITS-1];
      return !((&hi) || (~|hi));
   endfunction

   function automatic logic signed [OUT_BITS-1:0] sat_out(logic signed [WIDE-1:0] v);
      if (out_ovf(v))
         return v[WIDE-1] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
      return v[OUT_BITS-1:0];
   endfunction

endpackage

// File: hdl/eft_trig.sv
// Iterative CORDIC sine/cosine unit, three lanes sharing one step counter.
// Depends on eft_pkg.
module eft_trig (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [15:0]       angle_x,
   input  logic [15:0]       angle_y,
   input  logic [15:0]       angle_z,
   output eft_pkg::trig_type trig,
   output logic              busy
);

   logic                           run_ff, run_in;
   logic                           fin_ff, fin_in;
   logic [eft_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [eft_pkg::XW-1:0]  x_ff [3];
   logic signed [eft_pkg::XW-1:0]  x_in [3];
   logic signed [eft_pkg::XW-1:0]  y_ff [3];
   logic signed [eft_pkg::XW-1:0]  y_in [3];
   logic signed [eft_pkg::ZW-1:0]  z_ff [3];
   logic signed [eft_pkg::ZW-1:0]  z_in [3];
   logic [1:0]                     q_ff [3];
   logic [1:0]                     q_in [3];
   logic [15:0]                    ang [3];
   logic signed [eft_pkg::TRIG_BITS-1:0] cos_w [3];
   logic signed [eft_pkg::TRIG_BITS-1:0] sin_w [3];
   eft_pkg::trig_type              trig_ff, trig_in;

   assign ang[0] = angle_x;
   assign ang[1] = angle_y;
   assign ang[2] = angle_z;

   always_comb begin
      run_in = run_ff;
      fin_in = 1'b0;
      cnt_in = cnt_ff;
      for (int l = 0; l < 3; l++) begin
         x_in[l] = x_ff[l];
         y_in[l] = y_ff[l];
         z_in[l] = z_ff[l];
         q_in[l] = q_ff[l];
         if (start) begin
            x_in[l] = eft_pkg::CORDIC_GAIN;
            y_in[l] = '0;
            z_in[l] = eft_pkg::ZW'({ang[l][13:0], 16'h0000});
            q_in[l] = ang[l][15:14];
         end else if (run_ff) begin
            if (z_ff[l] >= 0) begin
               x_in[l] = x_ff[l] - (y_ff[l] >>> cnt_ff);
               y_in[l] = y_ff[l] + (x_ff[l] >>> cnt_ff);
               z_in[l] = z_ff[l] - eft_pkg::atan_turn(cnt_ff);
            end else begin
               x_in[l] = x_ff[l] + (y_ff[l] >>> cnt_ff);
               y_in[l] = y_ff[l] - (x_ff[l] >>> cnt_ff);
               z_in[l] = z_ff[l] + eft_pkg::atan_turn(cnt_ff);
            end
         end
      end
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == eft_pkg::CNT_W'(eft_pkg::CORDIC_STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   // Quadrant fold and rounding to trig codes.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         case (q_ff[l])
            2'd0: begin
               cos_w[l] = eft_pkg::to_trig((eft_pkg::XW+1)'(x_ff[l]));
               sin_w[l] = eft_pkg::to_trig((eft_pkg::XW+1)'(y_ff[l]));
            end
            2'd1: begin
               cos_w[l] = eft_pkg::to_trig(-(eft_pkg::XW+1)'(y_ff[l]));
               sin_w[l] = eft_pkg::to_trig((eft_pkg::XW+1)'(x_ff[l]));
            end
            2'd2: begin
               cos_w[l] = eft_pkg::to_trig(-(eft_pkg::XW+1)'(x_ff[l]));
               sin_w[l] = eft_pkg::to_trig(-(eft_pkg::XW+1)'(y_ff[l]));
            end
            default: begin
               cos_w[l] = eft_pkg::to_trig((eft_pkg::XW+1)'(y_ff[l]));
               sin_w[l] = eft_pkg::to_trig(-(eft_pkg::XW+1)'(x_ff[l]));
            end
         endcase
      end
      trig_in = trig_ff;
      if (fin_ff && !start) begin
         trig_in.cx = cos_w[0];
         trig_in.sx = sin_w[0];
         trig_in.cy = cos_w[1];
         trig_in.sy = sin_w[1];
         trig_in.cz = cos_w[2];
         trig_in.sz = sin_w[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         cnt_ff <= cnt_in;
      end
      for (int l = 0; l < 3; l++) begin
         x_ff[l] <= x_in[l];
         y_ff[l] <= y_in[l];
         z_ff[l] <= z_in[l];
         q_ff[l] <= q_in[l];
      end
      trig_ff <= trig_in;
   end

   assign trig = trig_ff;
   assign busy = run_ff | fin_ff;

endmodule

// File: hdl/eft_rot.sv
// One plane rotation of the point: a multiply stage and a round/saturate stage.
// Depends on eft_pkg.
module eft_rot (
   input  logic                 clock,
   input  logic                 reset,
   input  eft_pkg::rot_pos_type pos,
   input  eft_pkg::trig_type    trig,
   input  eft_pkg::stage_type   in_s,
   output eft_pkg::stage_type   out_s
);

   logic                                bwd;
   eft_pkg::axis_type                   axis_w;
   logic signed [eft_pkg::COORD_BITS-1:0] u_w, w_w;
   logic signed [eft_pkg::TRIG_BITS-1:0]  c_w, s_w;

   eft_pkg::stage_type                  a_ff, b_ff, b_in;
   eft_pkg::axis_type                   axis_ff;
   logic signed [eft_pkg::PROD_W-1:0]   uc_ff, ws_ff, us_ff, wc_ff;

   logic signed [eft_pkg::WIDE-1:0]     nu_w, nw_w;
   logic signed [eft_pkg::COORD_BITS-1:0] su_w, sw_w;
   logic                                ovf_w;

   assign bwd = (in_s.func == eft_pkg::FUNC_BWD) || (in_s.func == eft_pkg::FUNC_CHILD);

   always_comb begin
      unique case (pos)
         eft_pkg::ROT_FIRST: axis_w = bwd ? eft_pkg::AXIS_Z : eft_pkg::AXIS_X;
         eft_pkg::ROT_MID:   axis_w = eft_pkg::AXIS_Y;
         default:            axis_w = bwd ? eft_pkg::AXIS_X : eft_pkg::AXIS_Z;
      endcase
      // Rotation acts on the pair (u, w): u' = u*c - w*s, w' = u*s + w*c.
      unique case (axis_w)
         eft_pkg::AXIS_X: begin
            u_w = in_s.y; w_w = in_s.z; c_w = trig.cx; s_w = trig.sx;
         end
         eft_pkg::AXIS_Y: begin
            u_w = in_s.z; w_w = in_s.x; c_w = trig.cy; s_w = trig.sy;
         end
         default: begin
            u_w = in_s.x; w_w = in_s.y; c_w = trig.cz; s_w = trig.sz;
         end
      endcase
   end

   always_comb begin
      nu_w = (eft_pkg::WIDE'(uc_ff) - eft_pkg::WIDE'(ws_ff) + eft_pkg::PROD_HALF)
             >>> eft_pkg::TRIG_FRAC;
      nw_w = (eft_pkg::WIDE'(us_ff) + eft_pkg::WIDE'(wc_ff) + eft_pkg::PROD_HALF)
             >>> eft_pkg::TRIG_FRAC;
      su_w = eft_pkg::sat_coord(nu_w);
      sw_w = eft_pkg::sat_coord(nw_w);
      ovf_w = eft_pkg::coord_ovf(nu_w) | eft_pkg::coord_ovf(nw_w);
      b_in = a_ff;
      b_in.flag = a_ff.flag | ovf_w;
      unique case (axis_ff)
         eft_pkg::AXIS_X: begin b_in.y = su_w; b_in.z = sw_w; end
         eft_pkg::AXIS_Y: begin b_in.z = su_w; b_in.x = sw_w; end
         default:         begin b_in.x = su_w; b_in.y = sw_w; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= in_s.valid;
         b_ff.valid <= b_in.valid;
      end
      a_ff.func <= in_s.func;
      a_ff.flag <= in_s.flag;
      a_ff.x    <= in_s.x;
      a_ff.y    <= in_s.y;
      a_ff.z    <= in_s.z;
      axis_ff   <= axis_w;
      uc_ff     <= u_w * c_w;
      ws_ff     <= w_w * s_w;
      us_ff     <= u_w * s_w;
      wc_ff     <= w_w * c_w;
      b_ff.func <= b_in.func;
      b_ff.flag <= b_in.flag;
      b_ff.x    <= b_in.x;
      b_ff.y    <= b_in.y;
      b_ff.z    <= b_in.z;
   end

   assign out_s = b_ff;

endmodule

// File: hdl/eft_offset.sv
// Frame origin add or subtract stage, applied only for a matching function code.
// Depends on eft_pkg.
module eft_offset (
   input  logic                    clock,
   input  logic                    reset,
   input  eft_pkg::func_type       match,
   input  logic                    sub,
   input  logic signed [31:0]      offset_x,
   input  logic signed [31:0]      offset_y,
   input  logic signed [31:0]      offset_z,
   input  eft_pkg::stage_type      in_s,
   output eft_pkg::stage_type      out_s
);

   logic signed [eft_pkg::WIDE-1:0] o_w [3];
   logic signed [eft_pkg::WIDE-1:0] v_w [3];
   logic signed [eft_pkg::WIDE-1:0] r_w [3];
   logic signed [eft_pkg::WIDE-1:0] oc_w [3];
   logic                            ovf_w;
   eft_pkg::stage_type              s_ff, s_in;

   assign o_w[0] = eft_pkg::WIDE'(offset_x);
   assign o_w[1] = eft_pkg::WIDE'(offset_y);
   assign o_w[2] = eft_pkg::WIDE'(offset_z);
   assign v_w[0] = eft_pkg::WIDE'(in_s.x);
   assign v_w[1] = eft_pkg::WIDE'(in_s.y);
   assign v_w[2] = eft_pkg::WIDE'(in_s.z);

   always_comb begin
      ovf_w = 1'b0;
      for (int i = 0; i < 3; i++) begin
         oc_w[i] = eft_pkg::WIDE'(eft_pkg::sat_coord(o_w[i]));
         r_w[i]  = sub ? v_w[i] - oc_w[i] : v_w[i] + oc_w[i];
         ovf_w   = ovf_w | eft_pkg::coord_ovf(o_w[i]) | eft_pkg::coord_ovf(r_w[i]);
      end
      s_in = in_s;
      if (in_s.func == match) begin
         s_in.x    = eft_pkg::sat_coord(r_w[0]);
         s_in.y    = eft_pkg::sat_coord(r_w[1]);
         s_in.z    = eft_pkg::sat_coord(r_w[2]);
         s_in.flag = in_s.flag | ovf_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff.valid <= 1'b0;
      end else begin
         s_ff.valid <= s_in.valid;
      end
      s_ff.func <= s_in.func;
      s_ff.flag <= s_in.flag;
      s_ff.x    <= s_in.x;
      s_ff.y    <= s_in.y;
      s_ff.z    <= s_in.z;
   end

   assign out_s = s_ff;

endmodule

// File: hdl/euler_frame_point_transform_top.sv
// Euler frame point transform: rotates a Q16.16 point by three configured angles.
// Depends on eft_pkg, eft_trig, eft_rot and eft_offset.
//
// Usage:
//   Input: drive req_func and req_point_x/y/z with start high; the transfer
//   happens at the clock edge where start is high and busy is low.
//   Output: rsp_valid is high for exactly one cycle with rsp_result_x/y/z and
//   rsp_saturated; the receiver takes it at the edge ending that cycle and
//   cannot stall, so nothing in the pipeline ever waits.
//   Configuration: csr_we, csr_index, csr_wdata write one register per edge
//   (0..2 angles, 3..5 frame origin); other indexes are dropped.
// Timing:
//   Throughput is one point per cycle while busy is low: ten register stages
//   (input, origin subtract, three rotations of two stages each, origin add,
//   output). A write to an angle register restarts the CORDIC sine/cosine
//   unit, which holds busy high through the request, the 24 CORDIC
//   iterations and the fold and round.
// Reset:
//   Synchronous, active high. Clears the angle and origin registers to zero,
//   empties the pipeline and starts one sine/cosine computation, so busy is
//   high after reset is released until that computation is done.
module euler_frame_point_transform_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_x,
   output logic [31:0] rsp_result_y,
   output logic [31:0] rsp_result_z,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [15:0]        angle_x_ff, angle_y_ff, angle_z_ff;
   logic signed [31:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic               pend_ff, pend_in;
   logic               trig_busy;
   eft_pkg::trig_type  trig;

   eft_pkg::stage_type in_ff, in_in;
   eft_pkg::stage_type pre_s, rot1_s, rot2_s, rot3_s, post_s;

   logic signed [eft_pkg::WIDE-1:0] px_w, py_w, pz_w;
   logic signed [eft_pkg::WIDE-1:0] fx_w, fy_w, fz_w;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic               rsp_sat_ff;

   // Configuration writes; an angle write requests a fresh sine/cosine pass.
   always_comb begin
      pend_in = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            eft_pkg::CSR_ANGLE_X,
            eft_pkg::CSR_ANGLE_Y,
            eft_pkg::CSR_ANGLE_Z: pend_in = 1'b1;
            default:              pend_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff  <= '0;
         angle_y_ff  <= '0;
         angle_z_ff  <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
         pend_ff     <= 1'b1;
      end else begin
         pend_ff <= pend_in;
         if (csr_we) begin
            unique case (csr_index)
               eft_pkg::CSR_ANGLE_X:  angle_x_ff  <= csr_wdata[15:0];
               eft_pkg::CSR_ANGLE_Y:  angle_y_ff  <= csr_wdata[15:0];
               eft_pkg::CSR_ANGLE_Z:  angle_z_ff  <= csr_wdata[15:0];
               eft_pkg::CSR_OFFSET_X: offset_x_ff <= csr_wdata;
               eft_pkg::CSR_OFFSET_Y: offset_y_ff <= csr_wdata;
               eft_pkg::CSR_OFFSET_Z: offset_z_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   eft_trig u_trig (
      .clock   (clock),
      .reset   (reset),
      .start   (pend_ff),
      .angle_x (angle_x_ff),
      .angle_y (angle_y_ff),
      .angle_z (angle_z_ff),
      .trig    (trig),
      .busy    (trig_busy)
   );

   assign busy = pend_ff | trig_busy;

   // Input stage: capture the transfer and saturate to the internal width.
   always_comb begin
      px_w = eft_pkg::WIDE'($signed(req_point_x));
      py_w = eft_pkg::WIDE'($signed(req_point_y));
      pz_w = eft_pkg::WIDE'($signed(req_point_z));
      in_in.valid = start & ~busy;
      in_in.func  = eft_pkg::func_type'(req_func);
      in_in.x     = eft_pkg::sat_coord(px_w);
      in_in.y     = eft_pkg::sat_coord(py_w);
      in_in.z     = eft_pkg::sat_coord(pz_w);
      in_in.flag  = eft_pkg::coord_ovf(px_w) | eft_pkg::coord_ovf(py_w)
                    | eft_pkg::coord_ovf(pz_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else begin
         in_ff.valid <= in_in.valid;
      end
      in_ff.func <= in_in.func;
      in_ff.flag <= in_in.flag;
      in_ff.x    <= in_in.x;
      in_ff.y    <= in_in.y;
      in_ff.z    <= in_in.z;
   end

   // Into child frame: subtract the origin before rotating backward.
   eft_offset u_pre (
      .clock    (clock),
      .reset    (reset),
      .match    (eft_pkg::FUNC_CHILD),
      .sub      (1'b1),
      .offset_x (offset_x_ff),
      .offset_y (offset_y_ff),
      .offset_z (offset_z_ff),
      .in_s     (in_ff),
      .out_s    (pre_s)
   );

   eft_rot u_rot1 (
      .clock (clock),
      .reset (reset),
      .pos   (eft_pkg::ROT_FIRST),
      .trig  (trig),
      .in_s  (pre_s),
      .out_s (rot1_s)
   );

   eft_rot u_rot2 (
      .clock (clock),
      .reset (reset),
      .pos   (eft_pkg::ROT_MID),
      .trig  (trig),
      .in_s  (rot1_s),
      .out_s (rot2_s)
   );

   eft_rot u_rot3 (
      .clock (clock),
      .reset (reset),
      .pos   (eft_pkg::ROT_LAST),
      .trig  (trig),
      .in_s  (rot2_s),
      .out_s (rot3_s)
   );

   // Into parent frame: add the origin after rotating forward.
   eft_offset u_post (
      .clock    (clock),
      .reset    (reset),
      .match    (eft_pkg::FUNC_PARENT),
      .sub      (1'b0),
      .offset_x (offset_x_ff),
      .offset_y (offset_y_ff),
      .offset_z (offset_z_ff),
      .in_s     (rot3_s),
      .out_s    (post_s)
   );

   // Output stage: clip to 32 bits and present the result for one cycle.
   assign fx_w = eft_pkg::WIDE'(post_s.x);
   assign fy_w = eft_pkg::WIDE'(post_s.y);
   assign fz_w = eft_pkg::WIDE'(post_s.z);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= post_s.valid;
      end
      rsp_x_ff   <= eft_pkg::sat_out(fx_w);
      rsp_y_ff   <= eft_pkg::sat_out(fy_w);
      rsp_z_ff   <= eft_pkg::sat_out(fz_w);
      rsp_sat_ff <= post_s.flag | eft_pkg::out_ovf(fx_w) | eft_pkg::out_ovf(fy_w)
                    | eft_pkg::out_ovf(fz_w);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_x  = rsp_x_ff;
   assign rsp_result_y  = rsp_y_ff;
   assign rsp_result_z  = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// File: hdl/eft_checker.sv
// Port-level checker for the Euler frame point transform, bound to the top level.
// Depends on eft_pkg and euler_frame_point_transform_top_assert.svh.
`include "euler_frame_point_transform_top_assert.svh"

module eft_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        csr_we,
   input logic [2:0]  csr_index
);

   localparam int LAT = eft_pkg::PIPE_LAT;

   logic xfer;
   logic angle_wr;

   assign xfer     = start & ~busy;
   assign angle_wr = csr_we && (csr_index == eft_pkg::CSR_ANGLE_X
                     || csr_index == eft_pkg::CSR_ANGLE_Y
                     || csr_index == eft_pkg::CSR_ANGLE_Z);

   `EFT_ASSERT_IMPL(a_xfer_gives_rsp, clock, reset, xfer, ##LAT rsp_valid)
   `EFT_ASSERT_IMPL(a_no_xfer_no_rsp, clock, reset, !xfer, ##LAT !rsp_valid)
   `EFT_ASSERT_NEXT(a_angle_wr_busy, clock, reset, angle_wr, busy)
   `EFT_ASSERT_IMPL(a_busy_after_reset, clock, 1'b0, $fell(reset), busy)

endmodule

bind euler_frame_point_transform_top eft_checker u_eft_checker (.*);
